[rtl/core/idsa_pkg.sv]
// idsa_pkg: types, codes and default sizes for the id slot allocator
// no dependencies; imported by idsa_ctrl, idsa_dpath and the top level
package idsa_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MaxIdsDef     = 256;
  localparam int unsigned ChunkDef      = 32;
  localparam int unsigned HandleBitsDef = 32;

  // request modes
  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_PLACE   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_LOOKUP  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  // input word
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  slot_id;
    logic [31:0] handle;
  } idsa_in_t;

  // output word
  typedef struct packed {
    logic [7:0]  id_out;
    logic [31:0] handle_out;
    logic        is_valid;
    status_e     status;
  } idsa_out_t;

  // which kind of result the datapath builds
  typedef enum logic [2:0] {
    RES_ALLOC,
    RES_FULL,
    RES_RANGE,
    RES_WRITE,
    RES_LOOKUP
  } res_sel_e;

  // controller states
  typedef enum logic [3:0] {
    S_GROW,
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_ALLOC_WR,
    S_PLACE_WR,
    S_RELEASE,
    S_LOOKUP_RD,
    S_RESULT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_req;
    logic     grow_step;
    logic     pop_rd;
    logic     alloc_wr;
    logic     place_wr;
    logic     release_wr;
    logic     table_rd;
    logic     res_load;
    res_sel_e res_sel;
  } idsa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  id_ge_max;
    logic  id_ge_ceil;
    logic  stack_empty;
    logic  ceil_at_max;
    logic  grow_last;
  } idsa_sts_t;

endpackage

[rtl/core/idsa_dpath.sv]
// idsa_dpath: slot table, free id stack, ceiling and count registers, result register
// depends on idsa_pkg; driven by idsa_ctrl through idsa_cmd_t
module idsa_dpath #(
  parameter int unsigned MAX_IDS     = idsa_pkg::MaxIdsDef,
  parameter int unsigned CHUNK       = idsa_pkg::ChunkDef,
  parameter int unsigned HANDLE_BITS = idsa_pkg::HandleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  idsa_pkg::idsa_in_t  in_data_i,
  input  idsa_pkg::idsa_cmd_t cmd_i,
  output idsa_pkg::idsa_sts_t sts_o,
  output idsa_pkg::idsa_out_t out_data_o
);
  import idsa_pkg::*;

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  localparam int unsigned XW   = (IdW > 8) ? IdW : 8;
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;
  localparam int unsigned ChW  = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam int unsigned HW   = HANDLE_BITS;
  localparam int unsigned HXW  = (HW > 32) ? HW : 32;
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_IDS);
  localparam logic [ChW-1:0]  ChunkTop = ChW'(CHUNK - 1);

  // storage, no reset: every entry is written before it is read
  logic [HW-1:0]  slot_mem  [MAX_IDS];
  logic [IdW-1:0] stack_mem [MAX_IDS];

  logic [CntW-1:0] ceil_q, ceil_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ChW-1:0]  chunk_q, chunk_d;
  logic            ovf_q, ovf_d;

  mode_e          mode_q;
  logic [7:0]     id_q;
  logic [HW-1:0]  handle_q;
  logic [IdW-1:0] pop_q;
  logic [HW-1:0]  rd_q;
  idsa_out_t      out_q;

  logic [XW-1:0]   id_x;
  logic [IdW-1:0]  id_idx;
  logic [CntW-1:0] cnt_m1;
  logic [CntW-1:0] ceil_p1;
  logic            stack_full;
  logic [XW-1:0]   pop_x;
  logic [HXW-1:0]  rd_x;
  idsa_out_t       res;

  // id and index helpers
  assign id_x       = XW'(id_q);
  assign id_idx     = id_x[IdW-1:0];
  assign cnt_m1     = count_q - CntW'(1);
  assign ceil_p1    = ceil_q + CntW'(1);
  assign stack_full = (count_q == MaxCnt);
  assign pop_x      = XW'(pop_q);
  assign rd_x       = HXW'(rd_q);

  // status for the controller
  assign sts_o.mode        = mode_q;
  assign sts_o.id_ge_max   = (CmpW'(id_q) >= CmpW'(MaxCnt));
  assign sts_o.id_ge_ceil  = (CmpW'(id_q) >= CmpW'(ceil_q));
  assign sts_o.stack_empty = (count_q == '0);
  assign sts_o.ceil_at_max = (ceil_q == MaxCnt);
  assign sts_o.grow_last   = (chunk_q == ChunkTop) || (ceil_p1 == MaxCnt);

  // ceiling, count, chunk counter and overflow flag
  always_comb begin
    ceil_d  = ceil_q;
    count_d = count_q;
    chunk_d = chunk_q;
    ovf_d   = ovf_q;
    if (cmd_i.load_req) begin
      ovf_d = 1'b0;
    end
    if (cmd_i.grow_step) begin
      ceil_d  = ceil_p1;
      chunk_d = sts_o.grow_last ? '0 : chunk_q + ChW'(1);
      if (stack_full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.pop_rd) begin
      count_d = cnt_m1;
    end
    if (cmd_i.release_wr) begin
      if (stack_full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q  <= '0;
      count_q <= '0;
      chunk_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      ceil_q  <= ceil_d;
      count_q <= count_d;
      chunk_q <= chunk_d;
      ovf_q   <= ovf_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q   <= in_data_i.mode;
      id_q     <= in_data_i.slot_id;
      handle_q <= HW'(in_data_i.handle);
    end
  end

  // free id stack: push on growth and release, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.grow_step && !stack_full) begin
      stack_mem[count_q[IdW-1:0]] <= ceil_q[IdW-1:0];
    end else if (cmd_i.release_wr && !stack_full) begin
      stack_mem[count_q[IdW-1:0]] <= id_idx;
    end
    if (cmd_i.pop_rd) begin
      pop_q <= stack_mem[cnt_m1[IdW-1:0]];
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.grow_step) begin
      slot_mem[ceil_q[IdW-1:0]] <= '0;
    end else if (cmd_i.alloc_wr) begin
      slot_mem[pop_q] <= handle_q;
    end else if (cmd_i.place_wr) begin
      slot_mem[id_idx] <= handle_q;
    end else if (cmd_i.release_wr) begin
      slot_mem[id_idx] <= '0;
    end
    if (cmd_i.table_rd) begin
      rd_q <= slot_mem[id_idx];
    end
  end

  // result word
  always_comb begin
    res.id_out     = id_q;
    res.handle_out = '0;
    res.is_valid   = 1'b0;
    res.status     = ST_OK;
    case (cmd_i.res_sel)
      RES_ALLOC: begin
        res.id_out = pop_x[7:0];
      end
      RES_FULL: begin
        res.id_out = '0;
        res.status = ST_FULL;
      end
      RES_RANGE: begin
        res.status = ST_RANGE;
      end
      RES_WRITE: begin
        res.status = ovf_q ? ST_OVF : ST_OK;
      end
      RES_LOOKUP: begin
        res.handle_out = rd_x[31:0];
        res.is_valid   = |rd_q;
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

  // checks
  a_grow_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grow_step |-> (ceil_q < MaxCnt))
    else $error("growth step with ceiling at limit");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= MaxCnt) && (ceil_q <= MaxCnt))
    else $error("stack count or ceiling past limit");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_rd |=> (count_q == $past(cnt_m1)))
    else $error("pop did not decrement stack count");

endmodule

[rtl/core/idsa_ctrl.sv]
// idsa_ctrl: sequencing state machine for the id slot allocator
// depends on idsa_pkg; drives idsa_dpath through idsa_cmd_t
module idsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  idsa_pkg::idsa_sts_t sts_i,
  output idsa_pkg::idsa_cmd_t cmd_o
);
  import idsa_pkg::*;

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;
  logic     active_q, active_d;
  logic     oval_q, oval_d;
  logic     accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = oval_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_GROW;
      res_q    <= RES_RANGE;
      active_q <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      res_q    <= res_d;
      active_q <= active_d;
      oval_q   <= oval_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    active_d = active_q;
    oval_d   = oval_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.res_sel = res_q;
    case (state_q)
      S_GROW: begin
        cmd_o.grow_step = 1'b1;
        if (sts_i.grow_last) begin
          state_d = active_q ? S_DECIDE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          active_d       = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.mode)
          MODE_ALLOC: begin
            if (!sts_i.stack_empty) begin
              state_d = S_POP;
            end else if (!sts_i.ceil_at_max) begin
              state_d = S_GROW;
            end else begin
              res_d   = RES_FULL;
              state_d = S_RESULT;
            end
          end
          MODE_PLACE: begin
            if (sts_i.id_ge_max) begin
              res_d   = RES_RANGE;
              state_d = S_RESULT;
            end else if (sts_i.id_ge_ceil) begin
              state_d = S_GROW;
            end else begin
              state_d = S_PLACE_WR;
            end
          end
          MODE_RELEASE: begin
            if (sts_i.id_ge_ceil) begin
              res_d   = RES_RANGE;
              state_d = S_RESULT;
            end else begin
              state_d = S_RELEASE;
            end
          end
          default: begin
            if (sts_i.id_ge_ceil) begin
              res_d   = RES_RANGE;
              state_d = S_RESULT;
            end else begin
              state_d = S_LOOKUP_RD;
            end
          end
        endcase
      end
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd_o.alloc_wr = 1'b1;
        res_d          = RES_ALLOC;
        state_d        = S_RESULT;
      end
      S_PLACE_WR: begin
        cmd_o.place_wr = 1'b1;
        res_d          = RES_WRITE;
        state_d        = S_RESULT;
      end
      S_RELEASE: begin
        cmd_o.release_wr = 1'b1;
        res_d            = RES_WRITE;
        state_d          = S_RESULT;
      end
      S_LOOKUP_RD: begin
        cmd_o.table_rd = 1'b1;
        res_d          = RES_LOOKUP;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to be free
        if (!oval_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          oval_d         = 1'b1;
          active_d       = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // checks
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> !sts_i.stack_empty)
    else $error("pop from empty free stack");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECIDE) && active_q)
    else $error("accepted word not taken into decode");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> oval_q && !active_q)
    else $error("result load did not raise output valid");

endmodule

[rtl/core/id_slot_allocator_free_stack.sv]
// id_slot_allocator_free_stack: top level of the id slot allocator
// depends on idsa_pkg, idsa_ctrl and idsa_dpath
//
//   channel  direction  handshake                      word
//   in       input      in_valid_i / in_ready_o        in_data_i  (idsa_in_t)
//   out      output     out_valid_o / out_ready_i      out_data_o (idsa_out_t)
//
// full and out-of-range words go through S_DECIDE and S_RESULT; release, place and lookup add
// S_RELEASE, S_PLACE_WR or S_LOOKUP_RD, allocate S_POP and S_ALLOC_WR.
// each growth adds one id per S_GROW step (CHUNK, fewer near MAX_IDS), then decides again.
// after reset one growth of CHUNK ids runs before in_ready_o rises.
// a new word is taken while the previous result still waits in the output register.
// a finished word whose result finds that register still full waits for out_ready_i.
module id_slot_allocator_free_stack #(
  parameter int unsigned MAX_IDS     = idsa_pkg::MaxIdsDef,
  parameter int unsigned CHUNK       = idsa_pkg::ChunkDef,
  parameter int unsigned HANDLE_BITS = idsa_pkg::HandleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idsa_pkg::idsa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idsa_pkg::idsa_out_t out_data_o
);
  import idsa_pkg::*;

  idsa_cmd_t cmd;
  idsa_sts_t sts;

  // sequencer
  idsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  idsa_dpath #(
    .MAX_IDS     (MAX_IDS),
    .CHUNK       (CHUNK),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
